// ----- rtl/ille_pkg.sv -----
`timescale 1ns / 1ps
package ille_pkg;

    localparam int CAPACITY_DEF    = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int ACTION_W = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 9;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_INSERT_AT  = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_POP_BACK   = 3'd4,
        ACT_REMOVE_AT  = 3'd5,
        ACT_READ_AT    = 3'd6
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DECIDE,
        S_PF_A, S_PF_B, S_PB_A, S_PB_B,
        S_DF_A, S_DF_B, S_DB_A, S_DB_B, S_GIVE,
        S_WALK, S_RD, S_INS_A, S_INS_B, S_RM,
        S_FIN_H, S_FIN_T, S_FIN_O
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_INIT, OP_LOAD, OP_DECIDE,
        OP_PF_A, OP_PF_B, OP_PB_A, OP_PB_B,
        OP_DF_A, OP_DF_B, OP_DB_A, OP_DB_B, OP_GIVE,
        OP_WALK, OP_RD, OP_INS_A, OP_INS_B, OP_RM,
        OP_FIN_H, OP_FIN_T, OP_FIN_O
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status status;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    init_done;
        logic    len_zero;
        logic    full;
        logic    pos_gt_len;
        logic    pos_ge_len;
        logic    pos_zero;
        logic    pos_eq_len;
        logic    pos_eq_last;
        logic    walk_done;
        logic    out_free;
    } t_flags;

endpackage

// ----- rtl/ille_if.sv -----
`timescale 1ns / 1ps
interface ille_req_if;
    logic                               valid;
    logic                               ready;
    logic [ille_pkg::ACTION_W-1:0]      action;
    logic signed [ille_pkg::DATA_W-1:0] item_value;
    logic [ille_pkg::POS_W-1:0]         position;

    modport source (output valid, action, item_value, position, input ready);
    modport sink   (input valid, action, item_value, position, output ready);
endinterface

interface ille_res_if;
    logic                               valid;
    logic                               ready;
    logic [ille_pkg::STATUS_W-1:0]      status;
    logic signed [ille_pkg::DATA_W-1:0] read_value;
    logic signed [ille_pkg::DATA_W-1:0] front_value;
    logic signed [ille_pkg::DATA_W-1:0] back_value;
    logic [ille_pkg::COUNT_W-1:0]       entry_count;

    modport source (output valid, status, read_value, front_value, back_value, entry_count,
                    input ready);
    modport sink   (input valid, status, read_value, front_value, back_value, entry_count,
                    output ready);
endinterface

// ----- rtl/indexed_linked_list_engine.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Payload
// i_req     in   valid/ready    action, item_value, position
// o_res     out  valid/ready    status, read_value, front_value, back_value, entry_count
//
// After reset the free chain is built by a sweep over every node slot; no request
// is taken meanwhile. One request is worked at a time. Positional read, insert
// and remove walk position + 1 links at one node-memory read per cycle. A finished
// result waits in the output register; the engine stalls before loading the next
// result until the previous one is taken.
module indexed_linked_list_engine #(
    parameter int CAPACITY    = ille_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = ille_pkg::VALUE_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ille_req_if.sink     i_req,
    ille_res_if.source   o_res
);
    import ille_pkg::*;

    t_cmd   cmd;
    t_flags flags;
    logic   req_ready;

    // sequencer: decides the next step of the request from datapath status
    ille_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_flags     (flags),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    assign i_req.ready = req_ready;

    // node memories, links, counters and the result register
    ille_dp #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_action      (i_req.action),
        .i_item_value  (i_req.item_value),
        .i_position    (i_req.position),
        .i_out_ready   (o_res.ready),
        .o_flags       (flags),
        .o_out_valid   (o_res.valid),
        .o_status      (o_res.status),
        .o_read_value  (o_res.read_value),
        .o_front_value (o_res.front_value),
        .o_back_value  (o_res.back_value),
        .o_entry_count (o_res.entry_count)
    );

endmodule

// ----- rtl/ille_ctl.sv -----
`timescale 1ns / 1ps
module ille_ctl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  ille_pkg::t_flags i_flags,
    output logic            o_req_ready,
    output ille_pkg::t_cmd  o_cmd
);
    import ille_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_req_ready  = 1'b0;
        o_cmd.op     = OP_NONE;
        o_cmd.status = STAT_DONE;
        unique case (r_state)
            S_INIT: begin
                o_cmd.op = OP_INIT;
                if (i_flags.init_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.op = OP_DECIDE;
                n_state  = S_FIN_H;
                unique case (i_flags.act)
                    ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                        if (i_flags.full) o_cmd.status = STAT_FULL;
                        else if (i_flags.act == ACT_PUSH_FRONT) n_state = S_PF_A;
                        else n_state = S_PB_A;
                    end
                    ACT_INSERT_AT: begin
                        if (i_flags.pos_gt_len) o_cmd.status = STAT_RANGE;
                        else if (i_flags.full) o_cmd.status = STAT_FULL;
                        else if (i_flags.pos_zero) n_state = S_PF_A;
                        else if (i_flags.pos_eq_len) n_state = S_PB_A;
                        else n_state = S_WALK;
                    end
                    ACT_POP_FRONT, ACT_POP_BACK: begin
                        if (i_flags.len_zero) o_cmd.status = STAT_EMPTY;
                        else if (i_flags.act == ACT_POP_FRONT) n_state = S_DF_A;
                        else n_state = S_DB_A;
                    end
                    ACT_REMOVE_AT: begin
                        if (i_flags.pos_ge_len) o_cmd.status = STAT_RANGE;
                        else if (i_flags.pos_zero) n_state = S_DF_A;
                        else if (i_flags.pos_eq_last) n_state = S_DB_A;
                        else n_state = S_WALK;
                    end
                    ACT_READ_AT: begin
                        if (i_flags.pos_ge_len) o_cmd.status = STAT_RANGE;
                        else n_state = S_WALK;
                    end
                    default: n_state = S_FIN_H;
                endcase
            end
            S_PF_A:  begin o_cmd.op = OP_PF_A;  n_state = S_PF_B;  end
            S_PF_B:  begin o_cmd.op = OP_PF_B;  n_state = S_FIN_H; end
            S_PB_A:  begin o_cmd.op = OP_PB_A;  n_state = S_PB_B;  end
            S_PB_B:  begin o_cmd.op = OP_PB_B;  n_state = S_FIN_H; end
            S_DF_A:  begin o_cmd.op = OP_DF_A;  n_state = S_DF_B;  end
            S_DF_B:  begin o_cmd.op = OP_DF_B;  n_state = S_GIVE;  end
            S_DB_A:  begin o_cmd.op = OP_DB_A;  n_state = S_DB_B;  end
            S_DB_B:  begin o_cmd.op = OP_DB_B;  n_state = S_GIVE;  end
            S_GIVE:  begin o_cmd.op = OP_GIVE;  n_state = S_FIN_H; end
            S_WALK: begin
                o_cmd.op = OP_WALK;
                if (i_flags.walk_done) begin
                    if (i_flags.act == ACT_READ_AT) n_state = S_RD;
                    else if (i_flags.act == ACT_INSERT_AT) n_state = S_INS_A;
                    else n_state = S_RM;
                end
            end
            S_RD:    begin o_cmd.op = OP_RD;    n_state = S_FIN_H; end
            S_INS_A: begin o_cmd.op = OP_INS_A; n_state = S_INS_B; end
            S_INS_B: begin o_cmd.op = OP_INS_B; n_state = S_FIN_H; end
            S_RM:    begin o_cmd.op = OP_RM;    n_state = S_GIVE;  end
            S_FIN_H: begin o_cmd.op = OP_FIN_H; n_state = S_FIN_T; end
            S_FIN_T: begin o_cmd.op = OP_FIN_T; n_state = S_FIN_O; end
            S_FIN_O: begin
                o_cmd.op = OP_FIN_O;
                if (i_flags.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/ille_dp.sv -----
`timescale 1ns / 1ps
module ille_dp #(
    parameter int CAPACITY    = ille_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = ille_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ille_pkg::t_cmd                      i_cmd,
    input  logic [ille_pkg::ACTION_W-1:0]       i_action,
    input  logic signed [ille_pkg::DATA_W-1:0]  i_item_value,
    input  logic [ille_pkg::POS_W-1:0]          i_position,
    input  logic                                i_out_ready,
    output ille_pkg::t_flags                    o_flags,
    output logic                                o_out_valid,
    output logic [ille_pkg::STATUS_W-1:0]       o_status,
    output logic signed [ille_pkg::DATA_W-1:0]  o_read_value,
    output logic signed [ille_pkg::DATA_W-1:0]  o_front_value,
    output logic signed [ille_pkg::DATA_W-1:0]  o_back_value,
    output logic [ille_pkg::COUNT_W-1:0]        o_entry_count
);
    import ille_pkg::*;

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SW  = $clog2(CAPACITY + 1);
    localparam int CW  = ((SW > POS_W) ? SW : POS_W) + 1;
    localparam logic [SW-1:0] NIL = SW'(CAPACITY);

    // node stores
    logic [VALUE_WIDTH-1:0] r_mv [CAPACITY];
    logic [SW-1:0]          r_mn [CAPACITY];
    logic [SW-1:0]          r_mp [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_qv;
    logic [SW-1:0]          r_qn, r_qp;

    logic                   mv_we, mn_we, mp_we;
    logic [SW-1:0]          mv_wa, mn_wa, mp_wa, mn_wd, mp_wd;
    logic [SW-1:0]          av, an, ap;

    logic [SW-1:0]          r_head, r_tail, r_free, r_len, r_cur, r_s, r_p;
    logic [AW-1:0]          r_init;
    logic [POS_W-1:0]       r_cnt, r_pos;
    logic                   r_first;
    t_action                r_act;
    logic [VALUE_WIDTH-1:0] r_val;
    t_status                r_status;
    logic [DATA_W-1:0]      r_read, r_front;
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_o_status;
    logic [DATA_W-1:0]      r_o_read, r_o_front, r_o_back;
    logic [COUNT_W-1:0]     r_o_count;

    logic [SW-1:0]          cur_now;
    logic                   len_zero, len_le1, out_free;

    assign cur_now  = r_first ? r_cur : r_qn;
    assign len_zero = (r_len == '0);
    assign len_le1  = (r_len <= SW'(1));
    assign out_free = !r_out_valid || i_out_ready;

    assign o_flags.act         = r_act;
    assign o_flags.init_done   = (r_init == AW'(CAPACITY - 1));
    assign o_flags.len_zero    = len_zero;
    assign o_flags.full        = (r_len == SW'(CAPACITY)) || (r_free == NIL);
    assign o_flags.pos_gt_len  = CW'(r_pos) > CW'(r_len);
    assign o_flags.pos_ge_len  = CW'(r_pos) >= CW'(r_len);
    assign o_flags.pos_zero    = (r_pos == '0);
    assign o_flags.pos_eq_len  = CW'(r_pos) == CW'(r_len);
    assign o_flags.pos_eq_last = (CW'(r_pos) + CW'(1)) == CW'(r_len);
    assign o_flags.walk_done   = (r_cnt == '0);
    assign o_flags.out_free    = out_free;

    // memory port steering
    always_comb begin
        mv_we = 1'b0; mv_wa = r_free;
        mn_we = 1'b0; mn_wa = r_free; mn_wd = NIL;
        mp_we = 1'b0; mp_wa = r_free; mp_wd = NIL;
        av = cur_now; an = cur_now; ap = cur_now;
        unique case (i_cmd.op)
            OP_INIT: begin
                mn_we = 1'b1;
                mn_wa = SW'(r_init);
                mn_wd = SW'(r_init) + SW'(1);
            end
            OP_PF_A: begin
                an = r_free;
                mv_we = 1'b1;
                mp_we = 1'b1;
            end
            OP_PB_A: begin
                an = r_free;
                mv_we = 1'b1;
                mn_we = 1'b1;
                mp_we = 1'b1; mp_wd = r_tail;
            end
            OP_PF_B: begin
                mn_we = 1'b1; mn_wa = r_s; mn_wd = r_head;
                mp_we = !len_zero; mp_wa = r_head; mp_wd = r_s;
            end
            OP_PB_B: begin
                mn_we = !len_zero; mn_wa = r_tail; mn_wd = r_s;
            end
            OP_DF_A: an = r_head;
            OP_DF_B: begin
                mp_we = !len_le1; mp_wa = r_qn;
            end
            OP_DB_A: ap = r_tail;
            OP_DB_B: begin
                mn_we = !len_le1; mn_wa = r_qp;
            end
            OP_GIVE: begin
                mn_we = 1'b1; mn_wa = r_s; mn_wd = r_free;
            end
            OP_INS_A: begin
                an = r_free;
                mv_we = 1'b1;
                mn_we = 1'b1; mn_wd = r_cur;
                mp_we = 1'b1; mp_wd = r_qp;
            end
            OP_INS_B: begin
                mn_we = 1'b1; mn_wa = r_p; mn_wd = r_s;
                mp_we = 1'b1; mp_wa = r_cur; mp_wd = r_s;
            end
            OP_RM: begin
                mn_we = 1'b1; mn_wa = r_qp; mn_wd = r_qn;
                mp_we = 1'b1; mp_wa = r_qn; mp_wd = r_qp;
            end
            OP_FIN_H: av = r_head;
            OP_FIN_T, OP_FIN_O: av = r_tail;
            default: ;
        endcase
    end

    // read-first memories
    always_ff @(posedge i_clk) begin
        if (mv_we) r_mv[mv_wa[AW-1:0]] <= r_val;
        r_qv <= r_mv[av[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (mn_we) r_mn[mn_wa[AW-1:0]] <= mn_wd;
        r_qn <= r_mn[an[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (mp_we) r_mp[mp_wa[AW-1:0]] <= mp_wd;
        r_qp <= r_mp[ap[AW-1:0]];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= NIL;
            r_tail      <= NIL;
            r_free      <= '0;
            r_len       <= '0;
            r_init      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (i_cmd.op)
                OP_INIT: r_init <= r_init + AW'(1);
                OP_PF_B: begin
                    r_free <= r_qn;
                    r_head <= r_s;
                    if (len_zero) r_tail <= r_s;
                    r_len <= r_len + SW'(1);
                end
                OP_PB_B: begin
                    r_free <= r_qn;
                    r_tail <= r_s;
                    if (len_zero) r_head <= r_s;
                    r_len <= r_len + SW'(1);
                end
                OP_DF_B: begin
                    if (len_le1) begin
                        r_head <= NIL;
                        r_tail <= NIL;
                    end else begin
                        r_head <= r_qn;
                    end
                end
                OP_DB_B: begin
                    if (len_le1) begin
                        r_head <= NIL;
                        r_tail <= NIL;
                    end else begin
                        r_tail <= r_qp;
                    end
                end
                OP_GIVE: begin
                    r_free <= r_s;
                    r_len  <= r_len - SW'(1);
                end
                OP_INS_B: begin
                    r_free <= r_qn;
                    r_len  <= r_len + SW'(1);
                end
                OP_FIN_O: begin
                    if (out_free) r_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_act <= t_action'(i_action);
                r_val <= VALUE_WIDTH'($unsigned(i_item_value));
                r_pos <= i_position;
            end
            OP_DECIDE: begin
                r_status <= i_cmd.status;
                r_read   <= '0;
                r_cur    <= r_head;
                r_cnt    <= r_pos;
                r_first  <= 1'b1;
            end
            OP_WALK: begin
                r_cur   <= cur_now;
                r_first <= 1'b0;
                if (r_cnt != '0) r_cnt <= r_cnt - POS_W'(1);
            end
            OP_PF_A, OP_PB_A: r_s <= r_free;
            OP_INS_A: begin
                r_s <= r_free;
                r_p <= r_qp;
            end
            OP_DF_A: r_s <= r_head;
            OP_DB_A: r_s <= r_tail;
            OP_RM:   r_s <= r_cur;
            OP_RD:   r_read <= DATA_W'(r_qv);
            OP_FIN_T: r_front <= len_zero ? '0 : DATA_W'(r_qv);
            OP_FIN_O: begin
                if (out_free) begin
                    r_o_status <= r_status;
                    r_o_read   <= r_read;
                    r_o_front  <= r_front;
                    r_o_back   <= len_zero ? '0 : DATA_W'(r_qv);
                    r_o_count  <= COUNT_W'(r_len);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_read_value  = r_o_read;
    assign o_front_value = r_o_front;
    assign o_back_value  = r_o_back;
    assign o_entry_count = r_o_count;

`ifndef SYNTHESIS
    logic at_rest;
    assign at_rest = (i_cmd.op == OP_NONE) || (i_cmd.op == OP_LOAD);

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= SW'(CAPACITY))
        else $error("entry count above capacity");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        at_rest |-> ((r_len == '0) == (r_head == NIL)))
        else $error("head link disagrees with entry count");

    a_full_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        at_rest |-> ((r_len == SW'(CAPACITY)) == (r_free == NIL)))
        else $error("free chain disagrees with entry count");

    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != $past(r_len)) |->
        ((r_len == $past(r_len) + SW'(1)) || (r_len + SW'(1) == $past(r_len))))
        else $error("entry count moved by more than one");
`endif

endmodule

// ----- verif/indexed_linked_list_engine_tb.sv -----
`timescale 1ns / 1ps
module indexed_linked_list_engine_tb;
    import ille_pkg::*;

    localparam int CAP      = CAPACITY_DEF;
    localparam int WDOG_MAX = 20000;

    typedef struct packed {
        t_status          status;
        logic [DATA_W-1:0]  read_value;
        logic [DATA_W-1:0]  front_value;
        logic [DATA_W-1:0]  back_value;
        logic [COUNT_W-1:0] entry_count;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    ille_req_if req_ch ();
    ille_res_if res_ch ();

    indexed_linked_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Shadow list: the contents in order. The slot layout is not observable,
    // so a queue of values is enough.
    logic [DATA_W-1:0] shadow_list[$];
    t_list_result      pending_results[$];
    int                error_count;
    int                idle_cycles;
    bit                timed_out;

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Apply one request to the shadow list and return the result it causes.
    function automatic t_list_result apply_request(logic [ACTION_W-1:0] act,
                                                   logic [DATA_W-1:0] val,
                                                   logic [POS_W-1:0] pos);
        t_list_result r;
        int len;
        bit full;
        len  = shadow_list.size();
        full = (len >= CAP);
        r = '0;
        r.status = STAT_DONE;
        case (act)
            ACT_PUSH_FRONT: begin
                if (full) r.status = STAT_FULL;
                else shadow_list.push_front(val);
            end
            ACT_PUSH_BACK: begin
                if (full) r.status = STAT_FULL;
                else shadow_list.push_back(val);
            end
            ACT_INSERT_AT: begin
                if (pos > len) r.status = STAT_RANGE;
                else if (full) r.status = STAT_FULL;
                else shadow_list.insert(pos, val);
            end
            ACT_POP_FRONT: begin
                if (len == 0) r.status = STAT_EMPTY;
                else void'(shadow_list.pop_front());
            end
            ACT_POP_BACK: begin
                if (len == 0) r.status = STAT_EMPTY;
                else void'(shadow_list.pop_back());
            end
            ACT_REMOVE_AT: begin
                if (pos >= len) r.status = STAT_RANGE;
                else shadow_list.delete(pos);
            end
            ACT_READ_AT: begin
                if (pos >= len) r.status = STAT_RANGE;
                else r.read_value = shadow_list[pos];
            end
            default: ;
        endcase
        len = shadow_list.size();
        if (len != 0) begin
            r.front_value = shadow_list[0];
            r.back_value  = shadow_list[len-1];
        end
        r.entry_count = len[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        error_count++;
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // Send one request; the expectation is queued at the accepting edge.
    // Valid goes low between requests.
    task automatic send_request(logic [ACTION_W-1:0] act, logic [DATA_W-1:0] val,
                                logic [POS_W-1:0] pos);
        int gap;
        gap = draw_gap();
        repeat (gap + 1) @(posedge i_clk);
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.item_value <= val;
        req_ch.position   <= pos;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_results.push_back(apply_request(act, val, pos));
        req_ch.valid <= 1'b0;
    endtask

    // Hold the result ready low for random stretches; check each accepted result.
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("MISMATCH unexpected result at %0t", $realtime);
                end else begin
                    t_list_result want;
                    want = pending_results.pop_front();
                    if (res_ch.status != want.status)
                        report_mismatch("status", res_ch.status, want.status);
                    if (res_ch.read_value != want.read_value)
                        report_mismatch("read_value", res_ch.read_value, want.read_value);
                    if (res_ch.front_value != want.front_value)
                        report_mismatch("front_value", res_ch.front_value, want.front_value);
                    if (res_ch.back_value != want.back_value)
                        report_mismatch("back_value", res_ch.back_value, want.back_value);
                    if (res_ch.entry_count != want.entry_count)
                        report_mismatch("entry_count", res_ch.entry_count, want.entry_count);
                end
            end
            stall = draw_gap();
            if (stall > 0 && $urandom_range(0, 1)) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    // Watchdog: count cycles with no accepted handshake on either channel.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX && !timed_out) begin
            timed_out = 1'b1;
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // Every action and corner on an empty, short and one-entry list.
    task automatic test_directed();
        send_request(ACT_POP_FRONT, 0, 0);
        send_request(ACT_POP_BACK, 0, 0);
        send_request(ACT_READ_AT, 0, 0);
        send_request(ACT_REMOVE_AT, 0, 0);
        send_request(ACT_INSERT_AT, 32'h1234, 1);
        send_request(ACT_INSERT_AT, 32'h7FFF_FFFF, 0);
        send_request(ACT_PUSH_FRONT, 32'h8000_0000, 0);
        send_request(ACT_PUSH_BACK, 32'hFFFF_FFFF, 9'h1FF);
        send_request(ACT_INSERT_AT, 32'h5555_AAAA, 3);
        send_request(ACT_INSERT_AT, 32'hAAAA_5555, 2);
        send_request(ACT_READ_AT, 0, 2);
        send_request(ACT_READ_AT, 0, 9'h1FF);
        send_request(ACT_READ_AT, 0, 256);
        send_request(ACT_INSERT_AT, 0, 9'h1FF);
        send_request(3'd7, 32'hDEAD_BEEF, 9'h155);
        send_request(ACT_REMOVE_AT, 0, 2);
        send_request(ACT_REMOVE_AT, 0, 3);
        send_request(ACT_REMOVE_AT, 0, 0);
        send_request(ACT_REMOVE_AT, 0, POS_W'(shadow_list.size() - 1));
        send_request(ACT_POP_BACK, 0, 0);
        send_request(ACT_POP_FRONT, 0, 0);
        send_request(ACT_POP_FRONT, 0, 0);
        wait_drained();
    endtask

    // Fill to capacity, hit full on every push kind, read the far end, drain.
    task automatic test_full_list();
        while (shadow_list.size() < CAP)
            send_request($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
                         $urandom, 0);
        send_request(ACT_PUSH_FRONT, 1, 0);
        send_request(ACT_PUSH_BACK, 2, 0);
        send_request(ACT_INSERT_AT, 3, 100);
        send_request(ACT_INSERT_AT, 3, 256);
        send_request(ACT_INSERT_AT, 3, 257);
        send_request(ACT_READ_AT, 0, 255);
        send_request(ACT_REMOVE_AT, 0, 254);
        send_request(ACT_INSERT_AT, 32'h0BAD_F00D, 200);
        send_request(ACT_READ_AT, 0, 200);
        // Pause until every result is back before draining.
        wait_drained();
        while (shadow_list.size() > 0)
            send_request($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT, 0, 0);
        wait_drained();
    endtask

    // Random mix; positions mostly within the list and mostly small.
    task automatic test_random_mix(int count);
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pos;
        int len;
        for (int n = 0; n < count; n++) begin
            len = shadow_list.size();
            act = (len > 40) ? ACTION_W'($urandom_range(3, 6))
                             : ACTION_W'($urandom_range(0, 7));
            case ($urandom_range(0, 9))
                0:       pos = POS_W'($urandom);
                1:       pos = POS_W'(len);
                default: pos = (len == 0) ? '0 : POS_W'($urandom_range(0, len - 1));
            endcase
            send_request(act, rand_value(), pos);
        end
        wait_drained();
    endtask

    initial begin
        error_count       = 0;
        idle_cycles       = 0;
        timed_out         = 1'b0;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = '0;
        req_ch.item_value = '0;
        req_ch.position   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_list();
        test_random_mix(600);

        repeat (300) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/ille_pkg.sv
rtl/ille_if.sv
rtl/ille_ctl.sv
rtl/ille_dp.sv
rtl/indexed_linked_list_engine.sv
verif/indexed_linked_list_engine_tb.sv
